// File: rtl/adsr_envelope_generator_core_macros.svh
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication on clk, masked during reset.
`define ADSR_EGC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, masked during reset.
`define ADSR_EGC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/adsr_egc_pkg.sv
// Types, codes and constants of the envelope generator.
package adsr_egc_pkg;

  localparam int LEVEL_W     = 32;
  localparam int VEL_W       = 16;
  localparam int DUTY_W      = 12;
  localparam int DUTY_SHIFT  = 20;
  localparam int THR_W       = 17;
  localparam int STEEP_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int MUL_W       = 32;
  localparam int MUL_CNT_W   = $clog2(MUL_W);
  localparam int DIV_NUM_W   = 48;
  localparam int DIV_DEN_W   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 12'hfff;
  localparam logic [LEVEL_W-1:0] PEAK_BIAS     = 32'hffffffff;
  localparam logic [LEVEL_W-1:0] SUS_RESET     = 32'hffffffff;
  localparam logic [LEVEL_W-1:0] RATIO_CAP     = 32'hffff0000;
  localparam int                 FRAC_ONE      = 65536;
  localparam int                 TARGET_DIV    = 5;
  localparam logic [VEL_W-1:0]   ANA_ON_LEVEL  = 16'd22527;
  localparam logic [VEL_W-1:0]   ANA_VEL_BASE  = 16'd24000;
  localparam logic [VEL_W-1:0]   ANA_OFF_LEVEL = 16'd16384;
  localparam int                 ANA_VEL_SPAN  = 20768;
  localparam logic [VEL_W-1:0]   VEL_MAX       = 16'hffff;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_GATE_ON  = 2'd1,
    CMD_GATE_OFF = 2'd2,
    CMD_ANALOG   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ATTACK   = 2'd0,
    PH_DECAY    = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TRG_NONE    = 2'd0,
    TRG_DIGITAL = 2'd1,
    TRG_ANALOG  = 2'd2,
    TRG_RELEASE = 2'd3
  } trig_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_THR     = 3'd4,
    CFG_STEEP   = 3'd5,
    CFG_MODE    = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VEL_WAIT,
    ST_TRG,
    ST_TRG_SQ,
    ST_TRG_SCALE,
    ST_TRG_DIV,
    ST_STEP,
    ST_ATK,
    ST_DEC_TGT,
    ST_DEC_THR,
    ST_DEC_CMP,
    ST_DEC_DIV,
    ST_DEC_FAC,
    ST_DEC_RAT,
    ST_DEC_STEP,
    ST_REL,
    ST_DONE
  } state_t;

endpackage

// File: rtl/adsr_egc_if.sv
// Channel interfaces of the envelope generator: input, result and configuration.
interface adsr_egc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       cmd;
  logic [adsr_egc_pkg::VEL_W-1:0]   velocity;
  logic [adsr_egc_pkg::VEL_W-1:0]   adc_sample;
  modport source (output valid, cmd, velocity, adc_sample, input ready);
  modport sink (input valid, cmd, velocity, adc_sample, output ready);
endinterface

interface adsr_egc_out_if;
  logic                             valid;
  logic                             ready;
  logic [adsr_egc_pkg::DUTY_W-1:0]  pwm_duty;
  logic                             gate_indicator;
  logic [1:0]                       envelope_phase;
  modport source (output valid, pwm_duty, gate_indicator, envelope_phase, input ready);
  modport sink (input valid, pwm_duty, gate_indicator, envelope_phase, output ready);
endinterface

interface adsr_egc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [adsr_egc_pkg::CFG_IDX_W-1:0]   index;
  logic [adsr_egc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/adsr_egc_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
module adsr_egc_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [adsr_egc_pkg::MUL_W-1:0]   a,
  input  logic [adsr_egc_pkg::MUL_W-1:0]   b,
  output logic                             done,
  output logic [2*adsr_egc_pkg::MUL_W-1:0] prod
);

  logic                                 busy_r;
  logic                                 done_r;
  logic [adsr_egc_pkg::MUL_CNT_W-1:0]   cnt_r;
  logic [adsr_egc_pkg::MUL_W-1:0]       a_r;
  logic [2*adsr_egc_pkg::MUL_W-1:0]     p_r;
  logic [adsr_egc_pkg::MUL_W:0]         sum;
  logic                                 last;

  assign last = (cnt_r == adsr_egc_pkg::MUL_CNT_W'(adsr_egc_pkg::MUL_W - 1));

  // add the multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, p_r[2*adsr_egc_pkg::MUL_W-1:adsr_egc_pkg::MUL_W]} +
               (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + adsr_egc_pkg::MUL_CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{adsr_egc_pkg::MUL_W{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= {sum, p_r[adsr_egc_pkg::MUL_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// File: rtl/adsr_egc_div.sv
// Restoring divider, one quotient bit per cycle.
module adsr_egc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [adsr_egc_pkg::DIV_NUM_W-1:0] num,
  input  logic [adsr_egc_pkg::DIV_DEN_W-1:0] den,
  output logic                               done,
  output logic [adsr_egc_pkg::DIV_NUM_W-1:0] quo
);

  logic                                 busy_r;
  logic                                 done_r;
  logic [adsr_egc_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [adsr_egc_pkg::DIV_DEN_W-1:0]   den_r;
  logic [adsr_egc_pkg::DIV_DEN_W-1:0]   rem_r;
  logic [adsr_egc_pkg::DIV_NUM_W-1:0]   q_r;
  logic [adsr_egc_pkg::DIV_DEN_W:0]     trial;
  logic [adsr_egc_pkg::DIV_DEN_W:0]     diff;
  logic                                 fits;
  logic                                 last;

  assign last  = (cnt_r == adsr_egc_pkg::DIV_CNT_W'(adsr_egc_pkg::DIV_NUM_W - 1));
  // shift the next dividend bit into the remainder and try a subtract
  assign trial = {rem_r, q_r[adsr_egc_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + adsr_egc_pkg::DIV_CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[adsr_egc_pkg::DIV_DEN_W-1:0]
                    : trial[adsr_egc_pkg::DIV_DEN_W-1:0];
      q_r   <= {q_r[adsr_egc_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: rtl/adsr_envelope_generator_core.sv
// One envelope voice: gate commands queue a trigger, each tick reports the PWM duty and
// steps the attack, bent decay or release curve. Gate on, gate off and most analog samples
// use no arithmetic unit; an analog gate-on that carries a velocity goes through the
// 48-bit serial divider before the next item is taken. Every product goes through one
// shared bit-serial 32x32 multiplier and every quotient through one restoring divider. A
// finished result waits in the output register while the next item is taken.
`include "adsr_envelope_generator_core_macros.svh"

module adsr_envelope_generator_core (
  input  logic                  clk,
  input  logic                  rst_n,
  adsr_egc_in_if.sink           in_ch,
  adsr_egc_out_if.source        out_ch,
  adsr_egc_cfg_if.sink          cfg_ch
);

  // configuration
  logic [adsr_egc_pkg::LEVEL_W-1:0]  attack_r, decay_r, release_r, sus_r;
  logic [adsr_egc_pkg::THR_W-1:0]    thr_r;
  logic [adsr_egc_pkg::STEEP_W-1:0]  steep_r;
  logic                              mode_r;

  // envelope state
  adsr_egc_pkg::state_t              state_r, state_nxt;
  logic [adsr_egc_pkg::LEVEL_W-1:0]  now_r, now_nxt;
  logic [adsr_egc_pkg::LEVEL_W-1:0]  target_r, target_nxt;
  logic [adsr_egc_pkg::LEVEL_W-1:0]  peak_r, peak_nxt;
  adsr_egc_pkg::phase_t              phase_r, phase_nxt;
  adsr_egc_pkg::trig_t               pending_r, pending_nxt;
  logic [adsr_egc_pkg::VEL_W-1:0]    held_v_r, held_v_nxt;
  logic                              gate_on_r, gate_on_nxt;

  // per-tick scratch
  logic [adsr_egc_pkg::DUTY_W-1:0]   duty_r, duty_nxt;
  logic [adsr_egc_pkg::LEVEL_W-1:0]  dist_r, dist_nxt;
  logic [adsr_egc_pkg::LEVEL_W-1:0]  span_r, span_nxt;
  logic                              down_r, down_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic [adsr_egc_pkg::DUTY_W-1:0]   out_duty_r, out_duty_nxt;
  logic                              out_gate_r, out_gate_nxt;
  logic [1:0]                        out_phase_r, out_phase_nxt;

  // shared arithmetic
  logic                                 mul_start, mul_done;
  logic [adsr_egc_pkg::MUL_W-1:0]       mul_a, mul_b;
  logic [2*adsr_egc_pkg::MUL_W-1:0]     mul_prod;
  logic                                 div_start, div_done;
  logic [adsr_egc_pkg::DIV_NUM_W-1:0]   div_num, div_quo;
  logic [adsr_egc_pkg::DIV_DEN_W-1:0]   div_den;

  // helpers
  logic                                 in_acc, out_fire, cfg_acc;
  adsr_egc_pkg::cmd_t                   in_cmd;
  logic [adsr_egc_pkg::VEL_W-1:0]       gate_lvl, vel_base;
  logic                                 ana_on, ana_vel_div, ana_off;
  logic [adsr_egc_pkg::LEVEL_W-1:0]     mul_hi, shifted;
  logic [adsr_egc_pkg::DUTY_W-1:0]      duty_sat;
  logic [36:0]                          sq_x31;
  logic [37:0]                          lvl_sum;
  logic [34:0]                          peak_x6;
  logic [adsr_egc_pkg::LEVEL_W:0]       atk_sum;
  logic [adsr_egc_pkg::LEVEL_W-1:0]     atk_gap;
  logic                                 dec_down;
  logic [adsr_egc_pkg::LEVEL_W-1:0]     dec_dist, dec_span;
  logic [adsr_egc_pkg::DIV_NUM_W-1:0]   dist_sh;
  logic                                 bend_go;
  logic [adsr_egc_pkg::THR_W-1:0]       excess;
  logic [25:0]                          factor;
  logic [41:0]                          rat_full;
  logic [adsr_egc_pkg::LEVEL_W-1:0]     ratio;
  logic [adsr_egc_pkg::VEL_W-1:0]       vel_q;

  adsr_egc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  adsr_egc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready           = (state_r == adsr_egc_pkg::ST_IDLE);
  assign in_acc                = in_ch.valid & in_ch.ready;
  assign in_cmd                = adsr_egc_pkg::cmd_t'(in_ch.cmd);
  assign cfg_ch.ready          = 1'b1;
  assign cfg_acc               = cfg_ch.valid & cfg_ch.ready;
  assign out_fire              = out_valid_r & out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pwm_duty       = out_duty_r;
  assign out_ch.gate_indicator = out_gate_r;
  assign out_ch.envelope_phase = out_phase_r;

  // analog gate: the converter reads inverted, so the gate level is its complement
  assign gate_lvl    = ~in_ch.adc_sample;
  assign vel_base    = gate_lvl - adsr_egc_pkg::ANA_VEL_BASE;
  assign ana_on      = mode_r & ~gate_on_r & (gate_lvl > adsr_egc_pkg::ANA_ON_LEVEL);
  assign ana_vel_div = ana_on & (gate_lvl > adsr_egc_pkg::ANA_VEL_BASE);
  assign ana_off     = mode_r & gate_on_r & (gate_lvl < adsr_egc_pkg::ANA_OFF_LEVEL);
  assign vel_q       = (div_quo > adsr_egc_pkg::DIV_NUM_W'(adsr_egc_pkg::VEL_MAX))
                       ? adsr_egc_pkg::VEL_MAX : div_quo[adsr_egc_pkg::VEL_W-1:0];

  assign mul_hi   = mul_prod[2*adsr_egc_pkg::MUL_W-1:adsr_egc_pkg::MUL_W];
  assign shifted  = now_r >> adsr_egc_pkg::DUTY_SHIFT;
  assign duty_sat = (shifted > adsr_egc_pkg::LEVEL_W'(adsr_egc_pkg::DUTY_MAX))
                    ? adsr_egc_pkg::DUTY_MAX : shifted[adsr_egc_pkg::DUTY_W-1:0];

  // digital peak: (v*v*31 + bias) >> 6, with x31 as x32 minus x
  assign sq_x31  = {mul_prod[31:0], 5'b0} - {5'b0, mul_prod[31:0]};
  assign lvl_sum = {1'b0, sq_x31} + {6'b0, adsr_egc_pkg::PEAK_BIAS};
  assign peak_x6 = {1'b0, peak_r, 2'b0} + {2'b0, peak_r, 1'b0};

  assign atk_gap = (target_r > now_r) ? (target_r - now_r) : '0;
  assign atk_sum = {1'b0, now_r} + {1'b0, mul_hi};

  assign dec_down = (mul_hi <= now_r);
  assign dec_dist = dec_down ? (now_r - mul_hi) : (mul_hi - now_r);
  assign dec_span = dec_down ? ((peak_r >= mul_hi) ? (peak_r - mul_hi) : '0) : mul_hi;

  assign dist_sh  = {dist_r, 16'b0};
  assign bend_go  = (span_r != '0) && ({16'b0, dist_sh} > mul_prod);
  assign excess   = div_quo[adsr_egc_pkg::THR_W-1:0] - thr_r;
  assign factor   = 26'(adsr_egc_pkg::FRAC_ONE) + {1'b0, mul_prod[40:16]};
  assign rat_full = mul_prod[57:16];
  assign ratio    = (rat_full > {10'b0, adsr_egc_pkg::RATIO_CAP})
                    ? adsr_egc_pkg::RATIO_CAP : rat_full[31:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adsr_egc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            adsr_egc_pkg::CMD_TICK:   state_nxt = adsr_egc_pkg::ST_TRG;
            adsr_egc_pkg::CMD_ANALOG: begin
              if (ana_vel_div) state_nxt = adsr_egc_pkg::ST_VEL_WAIT;
            end
            default: state_nxt = adsr_egc_pkg::ST_IDLE;
          endcase
        end
      end
      adsr_egc_pkg::ST_VEL_WAIT: if (div_done) state_nxt = adsr_egc_pkg::ST_IDLE;
      adsr_egc_pkg::ST_TRG: begin
        case (pending_r)
          adsr_egc_pkg::TRG_DIGITAL: state_nxt = adsr_egc_pkg::ST_TRG_SQ;
          adsr_egc_pkg::TRG_ANALOG:  state_nxt = adsr_egc_pkg::ST_TRG_SCALE;
          default:                   state_nxt = adsr_egc_pkg::ST_STEP;
        endcase
      end
      adsr_egc_pkg::ST_TRG_SQ:    if (mul_done) state_nxt = adsr_egc_pkg::ST_TRG_SCALE;
      adsr_egc_pkg::ST_TRG_SCALE: state_nxt = adsr_egc_pkg::ST_TRG_DIV;
      adsr_egc_pkg::ST_TRG_DIV:   if (div_done) state_nxt = adsr_egc_pkg::ST_STEP;
      adsr_egc_pkg::ST_STEP: begin
        case (phase_r)
          adsr_egc_pkg::PH_ATTACK: state_nxt = adsr_egc_pkg::ST_ATK;
          adsr_egc_pkg::PH_DECAY:  state_nxt = adsr_egc_pkg::ST_DEC_TGT;
          default:                 state_nxt = adsr_egc_pkg::ST_REL;
        endcase
      end
      adsr_egc_pkg::ST_ATK:     if (mul_done) state_nxt = adsr_egc_pkg::ST_DONE;
      adsr_egc_pkg::ST_DEC_TGT: if (mul_done) state_nxt = adsr_egc_pkg::ST_DEC_THR;
      adsr_egc_pkg::ST_DEC_THR: state_nxt = adsr_egc_pkg::ST_DEC_CMP;
      adsr_egc_pkg::ST_DEC_CMP: begin
        if (mul_done) begin
          state_nxt = bend_go ? adsr_egc_pkg::ST_DEC_DIV : adsr_egc_pkg::ST_DEC_STEP;
        end
      end
      adsr_egc_pkg::ST_DEC_DIV:  if (div_done) state_nxt = adsr_egc_pkg::ST_DEC_FAC;
      adsr_egc_pkg::ST_DEC_FAC:  if (mul_done) state_nxt = adsr_egc_pkg::ST_DEC_RAT;
      adsr_egc_pkg::ST_DEC_RAT:  if (mul_done) state_nxt = adsr_egc_pkg::ST_DEC_STEP;
      adsr_egc_pkg::ST_DEC_STEP: if (mul_done) state_nxt = adsr_egc_pkg::ST_DONE;
      adsr_egc_pkg::ST_REL:      if (mul_done) state_nxt = adsr_egc_pkg::ST_DONE;
      adsr_egc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = adsr_egc_pkg::ST_IDLE;
      end
      default: state_nxt = adsr_egc_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    now_nxt       = now_r;
    target_nxt    = target_r;
    peak_nxt      = peak_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    held_v_nxt    = held_v_r;
    gate_on_nxt   = gate_on_r;
    duty_nxt      = duty_r;
    dist_nxt      = dist_r;
    span_nxt      = span_r;
    down_nxt      = down_r;
    out_valid_nxt = out_valid_r & ~out_fire;
    out_duty_nxt  = out_duty_r;
    out_gate_nxt  = out_gate_r;
    out_phase_nxt = out_phase_r;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    case (state_r)
      adsr_egc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            adsr_egc_pkg::CMD_TICK: duty_nxt = duty_sat;
            adsr_egc_pkg::CMD_GATE_ON: begin
              if (!mode_r) begin
                held_v_nxt  = in_ch.velocity;
                pending_nxt = adsr_egc_pkg::TRG_DIGITAL;
                gate_on_nxt = 1'b1;
              end
            end
            adsr_egc_pkg::CMD_GATE_OFF: begin
              if (!mode_r) begin
                pending_nxt = adsr_egc_pkg::TRG_RELEASE;
                gate_on_nxt = 1'b0;
              end
            end
            adsr_egc_pkg::CMD_ANALOG: begin
              if (ana_on) begin
                held_v_nxt  = '0;
                pending_nxt = adsr_egc_pkg::TRG_ANALOG;
                gate_on_nxt = 1'b1;
                // velocity = (level - base) * 32768 / span
                div_start   = ana_vel_div;
                div_num     = {17'b0, vel_base, 15'b0};
                div_den     = adsr_egc_pkg::DIV_DEN_W'(adsr_egc_pkg::ANA_VEL_SPAN);
              end else if (ana_off) begin
                pending_nxt = adsr_egc_pkg::TRG_RELEASE;
                gate_on_nxt = 1'b0;
              end
            end
            default: duty_nxt = duty_r;
          endcase
        end
      end
      adsr_egc_pkg::ST_VEL_WAIT: if (div_done) held_v_nxt = vel_q;
      adsr_egc_pkg::ST_TRG: begin
        case (pending_r)
          adsr_egc_pkg::TRG_DIGITAL: begin
            mul_start = 1'b1;
            mul_a     = {16'b0, held_v_r};
            mul_b     = {16'b0, held_v_r};
          end
          adsr_egc_pkg::TRG_ANALOG: peak_nxt = {1'b0, held_v_r, 15'b0};
          adsr_egc_pkg::TRG_RELEASE: begin
            target_nxt  = '0;
            phase_nxt   = adsr_egc_pkg::PH_RELEASED;
            pending_nxt = adsr_egc_pkg::TRG_NONE;
          end
          default: pending_nxt = adsr_egc_pkg::TRG_NONE;
        endcase
      end
      adsr_egc_pkg::ST_TRG_SQ: if (mul_done) peak_nxt = lvl_sum[37:6];
      adsr_egc_pkg::ST_TRG_SCALE: begin
        // attack target is 1.2 x peak
        div_start = 1'b1;
        div_num   = {13'b0, peak_x6};
        div_den   = adsr_egc_pkg::DIV_DEN_W'(adsr_egc_pkg::TARGET_DIV);
      end
      adsr_egc_pkg::ST_TRG_DIV: begin
        if (div_done) begin
          target_nxt  = div_quo[adsr_egc_pkg::LEVEL_W-1:0];
          phase_nxt   = adsr_egc_pkg::PH_ATTACK;
          pending_nxt = adsr_egc_pkg::TRG_NONE;
        end
      end
      adsr_egc_pkg::ST_STEP: begin
        mul_start = 1'b1;
        case (phase_r)
          adsr_egc_pkg::PH_ATTACK: begin
            mul_a = atk_gap;
            mul_b = attack_r;
          end
          adsr_egc_pkg::PH_DECAY: begin
            mul_a = peak_r;
            mul_b = sus_r;
          end
          default: begin
            mul_a = now_r;
            mul_b = release_r;
          end
        endcase
      end
      adsr_egc_pkg::ST_ATK: begin
        if (mul_done) begin
          // snap to the peak once reached
          if (atk_sum >= {1'b0, peak_r}) begin
            now_nxt   = peak_r;
            phase_nxt = adsr_egc_pkg::PH_DECAY;
          end else begin
            now_nxt = atk_sum[adsr_egc_pkg::LEVEL_W-1:0];
          end
        end
      end
      adsr_egc_pkg::ST_DEC_TGT: begin
        if (mul_done) begin
          target_nxt = mul_hi;
          dist_nxt   = dec_dist;
          span_nxt   = dec_span;
          down_nxt   = dec_down;
        end
      end
      adsr_egc_pkg::ST_DEC_THR: begin
        mul_start = 1'b1;
        mul_a     = span_r;
        mul_b     = {15'b0, thr_r};
      end
      adsr_egc_pkg::ST_DEC_CMP: begin
        if (mul_done) begin
          if (bend_go) begin
            div_start = 1'b1;
            div_num   = dist_sh;
            div_den   = span_r;
          end else begin
            mul_start = 1'b1;
            mul_a     = dist_r;
            mul_b     = decay_r;
          end
        end
      end
      adsr_egc_pkg::ST_DEC_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = {15'b0, excess};
          mul_b     = {8'b0, steep_r};
        end
      end
      adsr_egc_pkg::ST_DEC_FAC: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = decay_r;
          mul_b     = {6'b0, factor};
        end
      end
      adsr_egc_pkg::ST_DEC_RAT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = dist_r;
          mul_b     = ratio;
        end
      end
      adsr_egc_pkg::ST_DEC_STEP: begin
        if (mul_done) now_nxt = down_r ? (now_r - mul_hi) : (now_r + mul_hi);
      end
      adsr_egc_pkg::ST_REL: if (mul_done) now_nxt = now_r - mul_hi;
      adsr_egc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_r;
          out_gate_nxt  = (phase_r != adsr_egc_pkg::PH_RELEASED);
          out_phase_nxt = phase_r;
        end
      end
      default: out_valid_nxt = out_valid_r & ~out_fire;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adsr_egc_pkg::ST_IDLE;
      now_r       <= '0;
      target_r    <= '0;
      peak_r      <= '0;
      phase_r     <= adsr_egc_pkg::PH_RELEASED;
      pending_r   <= adsr_egc_pkg::TRG_RELEASE;
      held_v_r    <= '0;
      gate_on_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      target_r    <= target_nxt;
      peak_r      <= peak_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      held_v_r    <= held_v_nxt;
      gate_on_r   <= gate_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    duty_r      <= duty_nxt;
    dist_r      <= dist_nxt;
    span_r      <= span_nxt;
    down_r      <= down_nxt;
    out_duty_r  <= out_duty_nxt;
    out_gate_r  <= out_gate_nxt;
    out_phase_r <= out_phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      release_r <= '0;
      sus_r     <= adsr_egc_pkg::SUS_RESET;
      thr_r     <= '0;
      steep_r   <= '0;
      mode_r    <= 1'b0;
    end else if (cfg_acc) begin
      case (adsr_egc_pkg::cfg_idx_t'(cfg_ch.index))
        adsr_egc_pkg::CFG_ATTACK:  attack_r  <= cfg_ch.data;
        adsr_egc_pkg::CFG_DECAY:   decay_r   <= cfg_ch.data;
        adsr_egc_pkg::CFG_RELEASE: release_r <= cfg_ch.data;
        adsr_egc_pkg::CFG_SUSTAIN: sus_r     <= cfg_ch.data;
        adsr_egc_pkg::CFG_THR:     thr_r     <= cfg_ch.data[adsr_egc_pkg::THR_W-1:0];
        adsr_egc_pkg::CFG_STEEP:   steep_r   <= cfg_ch.data[adsr_egc_pkg::STEEP_W-1:0];
        adsr_egc_pkg::CFG_MODE:    mode_r    <= cfg_ch.data[0];
        default:                   mode_r    <= mode_r;
      endcase
    end
  end

  `ADSR_EGC_ASSERT_NXT(a_tick_starts_trigger,
    in_acc && in_cmd == adsr_egc_pkg::CMD_TICK, state_r == adsr_egc_pkg::ST_TRG,
    "tick item did not enter trigger handling")
  `ADSR_EGC_ASSERT_IMP(a_trigger_consumed,
    state_r == adsr_egc_pkg::ST_STEP, pending_r == adsr_egc_pkg::TRG_NONE,
    "pending trigger left before curve step")
  `ADSR_EGC_ASSERT_IMP(a_decay_bounded,
    state_r == adsr_egc_pkg::ST_STEP && phase_r == adsr_egc_pkg::PH_DECAY, now_r <= peak_r,
    "decay level above peak")
  `ADSR_EGC_ASSERT_IMP(a_result_from_done,
    $rose(out_valid_r), $past(state_r) == adsr_egc_pkg::ST_DONE,
    "result loaded outside completion")
  `ADSR_EGC_ASSERT_IMP(a_div_owner,
    div_done, state_r == adsr_egc_pkg::ST_VEL_WAIT || state_r == adsr_egc_pkg::ST_TRG_DIV
      || state_r == adsr_egc_pkg::ST_DEC_DIV,
    "divider result with no consumer")

endmodule
